@@ design/roman_numeral_difference_macros.svh @@
// assertion helpers for the roman numeral difference block
`ifndef ROMAN_NUMERAL_DIFFERENCE_MACROS_SVH
`define ROMAN_NUMERAL_DIFFERENCE_MACROS_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define RND_ASSERT_IMP(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("roman numeral difference check failed");

// next-cycle implication, clocked on i_clk, off during reset
`define RND_ASSERT_NXT(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("roman numeral difference check failed");

`endif

@@ design/rnd_pkg.sv @@
package rnd_pkg;

    localparam logic [11:0] MAX_MAGNITUDE = 12'd3999;

    // symbol codes
    localparam logic [2:0] SYM_I = 3'd0;
    localparam logic [2:0] SYM_V = 3'd1;
    localparam logic [2:0] SYM_X = 3'd2;
    localparam logic [2:0] SYM_L = 3'd3;
    localparam logic [2:0] SYM_C = 3'd4;
    localparam logic [2:0] SYM_D = 3'd5;
    localparam logic [2:0] SYM_M = 3'd6;

    // ascii characters
    localparam logic [6:0] CHR_I = 7'h49;
    localparam logic [6:0] CHR_V = 7'h56;
    localparam logic [6:0] CHR_X = 7'h58;
    localparam logic [6:0] CHR_L = 7'h4C;
    localparam logic [6:0] CHR_C = 7'h43;
    localparam logic [6:0] CHR_D = 7'h44;
    localparam logic [6:0] CHR_M = 7'h4D;
    localparam logic [6:0] CHR_Z = 7'h5A;
    localparam logic [6:0] CHR_E = 7'h45;
    localparam logic [6:0] CHR_R = 7'h52;
    localparam logic [6:0] CHR_O = 7'h4F;

    localparam int          NUM_TOKENS = 13;
    localparam int          TOK_IDX_W  = $clog2(NUM_TOKENS);
    localparam logic [1:0]  ZERO_LAST  = 2'd3;

    typedef struct packed {
        logic [2:0] symbol;
        logic       second_numeral;
        logic       end_of_numeral;
    } t_in_item;

    typedef struct packed {
        logic [6:0] out_char;
        logic       last_char;
        logic       saturated;
    } t_out_item;

    typedef struct packed {
        logic accept;
        logic close;
        logic diff;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic second;
        logic done;
    } t_stat;

    function automatic logic [9:0] f_sym_val(input logic [2:0] sym);
        logic [9:0] v;
        unique case (sym)
            SYM_I:   v = 10'd1;
            SYM_V:   v = 10'd5;
            SYM_X:   v = 10'd10;
            SYM_L:   v = 10'd50;
            SYM_C:   v = 10'd100;
            SYM_D:   v = 10'd500;
            default: v = 10'd1000;
        endcase
        return v;
    endfunction

    // greedy token table: M CM D CD C XC L XL X IX V IV I
    function automatic logic [11:0] f_tok_val(input logic [TOK_IDX_W-1:0] idx);
        logic [11:0] v;
        unique case (idx)
            4'd0:    v = 12'd1000;
            4'd1:    v = 12'd900;
            4'd2:    v = 12'd500;
            4'd3:    v = 12'd400;
            4'd4:    v = 12'd100;
            4'd5:    v = 12'd90;
            4'd6:    v = 12'd50;
            4'd7:    v = 12'd40;
            4'd8:    v = 12'd10;
            4'd9:    v = 12'd9;
            4'd10:   v = 12'd5;
            4'd11:   v = 12'd4;
            default: v = 12'd1;
        endcase
        return v;
    endfunction

    function automatic logic [6:0] f_tok_c1(input logic [TOK_IDX_W-1:0] idx);
        logic [6:0] c;
        unique case (idx)
            4'd0:    c = CHR_M;
            4'd1:    c = CHR_C;
            4'd2:    c = CHR_D;
            4'd3:    c = CHR_C;
            4'd4:    c = CHR_C;
            4'd5:    c = CHR_X;
            4'd6:    c = CHR_L;
            4'd7:    c = CHR_X;
            4'd8:    c = CHR_X;
            4'd9:    c = CHR_I;
            4'd10:   c = CHR_V;
            default: c = CHR_I;
        endcase
        return c;
    endfunction

    function automatic logic [6:0] f_tok_c2(input logic [TOK_IDX_W-1:0] idx);
        logic [6:0] c;
        unique case (idx)
            4'd1:    c = CHR_M;
            4'd3:    c = CHR_D;
            4'd5:    c = CHR_C;
            4'd7:    c = CHR_L;
            4'd9:    c = CHR_X;
            default: c = CHR_V;
        endcase
        return c;
    endfunction

    // subtractive pairs sit at the odd slots
    function automatic logic f_tok_two(input logic [TOK_IDX_W-1:0] idx);
        return idx[0] && (idx < TOK_IDX_W'(NUM_TOKENS - 1));
    endfunction

    function automatic logic [6:0] f_zero_char(input logic [1:0] idx);
        logic [6:0] c;
        unique case (idx)
            2'd0:    c = CHR_Z;
            2'd1:    c = CHR_E;
            2'd2:    c = CHR_R;
            default: c = CHR_O;
        endcase
        return c;
    endfunction

endpackage

@@ design/rnd_ctrl.sv @@
module rnd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_end,
    input  rnd_pkg::t_stat i_stat,
    output rnd_pkg::t_cmd  o_cmd,
    output logic          o_in_stall
);
    import rnd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CLOSE = 4'b0010,
        S_DIFF  = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_end) n_state = S_CLOSE;
            end
            S_CLOSE: begin
                n_state = i_stat.second ? S_DIFF : S_IDLE;
            end
            S_DIFF: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.done) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_cmd.accept = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.close  = (r_state == S_CLOSE);
    assign o_cmd.diff   = (r_state == S_DIFF);
    assign o_cmd.emit   = (r_state == S_EMIT);

endmodule

@@ design/rnd_datapath.sv @@
module rnd_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rnd_pkg::t_cmd     i_cmd,
    input  rnd_pkg::t_in_item i_in,
    input  logic              i_out_stall,
    output rnd_pkg::t_stat    o_stat,
    output logic              o_out_valid,
    output rnd_pkg::t_out_item o_out
);
    import rnd_pkg::*;

    localparam logic signed [13:0] MAX_S  = $signed({2'b00, MAX_MAGNITUDE});
    localparam logic signed [13:0] MIN_S  = -MAX_S;
    localparam logic signed [12:0] MAX_13 = $signed({1'b0, MAX_MAGNITUDE});

    logic [11:0]           r_first;
    logic signed [12:0]    r_run;
    logic [2:0]            r_held;
    logic                  r_held_vld;
    logic                  r_ovf;
    logic [2:0]            r_cur;
    logic                  r_second;
    logic [11:0]           r_rem;
    logic [TOK_IDX_W-1:0]  r_idx;
    logic                  r_half;
    logic                  r_zero;
    logic [1:0]            r_zidx;
    logic                  r_out_vld;
    t_out_item             r_out;

    logic [2:0]            in_sym;
    logic signed [10:0]    held_s;
    logic signed [10:0]    cur_s;
    logic signed [10:0]    add_delta;
    logic signed [13:0]    add_sum;
    logic signed [12:0]    add_res;
    logic                  add_ovf;
    logic [11:0]           total;
    logic signed [12:0]    diff_s;
    logic [12:0]           diff_mag;
    logic                  diff_ovf;
    logic [11:0]           diff_val;

    logic                  out_free;
    logic                  emit_go;
    logic [11:0]           tv;
    logic                  ld;
    logic [6:0]            ld_char;
    logic                  ld_last;
    logic [11:0]           n_rem;
    logic [TOK_IDX_W-1:0]  n_idx;
    logic                  n_half;

    // code 7 is taken as M
    assign in_sym = (i_in.symbol > SYM_M) ? SYM_M : i_in.symbol;

    // one saturating adder shared by symbol accept and numeral close
    always_comb begin
        held_s    = $signed({1'b0, f_sym_val(r_held)});
        cur_s     = $signed({1'b0, f_sym_val(r_cur)});
        add_delta = i_cmd.accept ? ((r_held < in_sym) ? -held_s : held_s) : cur_s;
        add_sum   = $signed({r_run[12], r_run}) + $signed({{3{add_delta[10]}}, add_delta});
        add_ovf   = 1'b0;
        if (add_sum > MAX_S) begin
            add_res = MAX_13;
            add_ovf = 1'b1;
        end else if (add_sum < MIN_S) begin
            add_res = -MAX_13;
        end else begin
            add_res = add_sum[12:0];
        end
        total = add_res[12] ? 12'd0 : add_res[11:0];
    end

    always_comb begin
        diff_s   = $signed({1'b0, r_first}) - $signed({1'b0, r_rem});
        diff_mag = diff_s[12] ? (13'd0 - 13'(diff_s)) : 13'(diff_s);
        diff_ovf = diff_mag > {1'b0, MAX_MAGNITUDE};
        diff_val = diff_ovf ? MAX_MAGNITUDE : diff_mag[11:0];
    end

    assign out_free = !r_out_vld || !i_out_stall;
    assign emit_go  = i_cmd.emit && out_free;
    assign tv       = f_tok_val(r_idx);

    // one character per step; a step that finds no fitting token moves to the next one
    always_comb begin
        ld      = 1'b0;
        ld_char = CHR_I;
        ld_last = 1'b0;
        n_rem   = r_rem;
        n_idx   = r_idx;
        n_half  = r_half;
        if (emit_go) begin
            if (r_zero) begin
                ld      = 1'b1;
                ld_char = f_zero_char(r_zidx);
                ld_last = (r_zidx == ZERO_LAST);
            end else if (r_half) begin
                ld      = 1'b1;
                ld_char = f_tok_c2(r_idx);
                ld_last = (r_rem == tv);
                n_rem   = r_rem - tv;
                n_half  = 1'b0;
            end else if (r_rem >= tv) begin
                ld      = 1'b1;
                ld_char = f_tok_c1(r_idx);
                if (f_tok_two(r_idx)) begin
                    n_half = 1'b1;
                end else begin
                    ld_last = (r_rem == tv);
                    n_rem   = r_rem - tv;
                end
            end else begin
                n_idx = r_idx + TOK_IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first    <= 12'd0;
            r_run      <= 13'sd0;
            r_held     <= SYM_I;
            r_held_vld <= 1'b0;
            r_ovf      <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                if (r_held_vld) begin
                    r_run <= add_res;
                    if (add_ovf) r_ovf <= 1'b1;
                end
                r_cur    <= in_sym;
                r_second <= i_in.second_numeral;
                if (i_in.end_of_numeral) begin
                    r_held     <= SYM_I;
                    r_held_vld <= 1'b0;
                end else begin
                    r_held     <= in_sym;
                    r_held_vld <= 1'b1;
                end
            end
            if (i_cmd.close) begin
                r_run <= 13'sd0;
                if (add_ovf) r_ovf <= 1'b1;
                if (r_second) begin
                    r_rem <= total;
                end else begin
                    r_first <= total;
                end
            end
            if (i_cmd.diff) begin
                r_rem  <= diff_val;
                r_zero <= (diff_val == 12'd0);
                r_idx  <= '0;
                r_half <= 1'b0;
                r_zidx <= 2'd0;
                if (diff_ovf) r_ovf <= 1'b1;
            end
            if (emit_go) begin
                r_rem  <= n_rem;
                r_idx  <= n_idx;
                r_half <= n_half;
                if (ld) r_zidx <= r_zidx + 2'd1;
                if (ld_last) begin
                    r_first <= 12'd0;
                    r_ovf   <= 1'b0;
                end
            end
            if (ld) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld) begin
            r_out.out_char  <= ld_char;
            r_out.last_char <= ld_last;
            r_out.saturated <= r_ovf;
        end
    end

    assign o_stat.second = r_second;
    assign o_stat.done   = ld && ld_last;
    assign o_out_valid   = r_out_vld;
    assign o_out         = r_out;

endmodule

@@ design/roman_numeral_difference.sv @@
// roman numeral difference
// input channel: one symbol item per unstalled cycle (i_in_valid / o_in_stall),
// each item a symbol code, the numeral it belongs to and an end-of-numeral mark
// output channel: up to one ascii character item per cycle (o_out_valid /
// i_out_stall), last_char on the final character of a run, saturated on every
// character of a run after any clamp to 3999
// symbols without the end mark are taken back to back, without a stall
// end of the first numeral: accept, then close through the shared adder
// end of the second numeral: accept, close, difference, then the character run
// the run walks a 13-entry token table (M CM D CD C XC L XL X IX V IV I) with one
// step per cycle while the receiver does not stall: a step either emits one
// character or moves to the next token, and a zero difference is spelled ZERO
// after an end item the input stalls for the close and, for a second numeral,
// until the last character is loaded into the output register; while the receiver
// stalls the character holds and the run pauses
// reset (synchronous, active low) clears totals, held symbol, flag and output valid
module roman_numeral_difference (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  rnd_pkg::t_in_item  i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output rnd_pkg::t_out_item o_out
);
    import rnd_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    rnd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_end      (i_in.end_of_numeral),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    rnd_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in        (i_in),
        .i_out_stall (i_out_stall),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

@@ design/rnd_checker.sv @@
`include "roman_numeral_difference_macros.svh"

module rnd_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input rnd_pkg::t_in_item  i_in,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input rnd_pkg::t_out_item o_out
);
    import rnd_pkg::*;

    // a stalled character holds
    `RND_ASSERT_NXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out))

    // no symbol is taken in the middle of a run
    `RND_ASSERT_IMP(a_in_blocked, o_out_valid && !o_out.last_char, o_in_stall)

    // Z is always followed straight away by E
    `RND_ASSERT_NXT(a_zero_seq, o_out_valid && !i_out_stall && o_out.out_char == CHR_Z,
        o_out_valid && o_out.out_char == CHR_E)

    // the input stalls only after an end item is taken
    `RND_ASSERT_NXT(a_stall_cause, !o_in_stall && !(i_in_valid && i_in.end_of_numeral),
        !o_in_stall)

endmodule

bind roman_numeral_difference rnd_checker u_rnd_checker (.*);

@@ tb/sv/tb.sv @@
module tb;
    import rnd_pkg::*;

    localparam int         SAT_LIMIT      = int'(MAX_MAGNITUDE);
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         ITEM_TARGET    = 170;
    localparam int         QUIET_FROM     = 140;
    localparam int         TAIL_CYCLES    = 20;
    // out-of-range code, decoded as M
    localparam logic [2:0] SYM_M_ALIAS    = 3'd7;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_item  in_item   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_item;

    // decoder state mirrored from the block
    int         first_sum  = 0;
    int         run_sum    = 0;
    logic [2:0] held_sym   = SYM_I;
    logic       held_ok    = 1'b0;
    logic       clamp_seen = 1'b0;
    t_out_item  char_q[$];

    int err_cnt     = 0;
    int sent_cnt    = 0;
    int idle_cycles = 0;
    int stall_left  = 0;
    bit quiet       = 1'b0;

    roman_numeral_difference i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in       (in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out      (out_item)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int sym_weight(input logic [2:0] s);
        case (s)
            SYM_I:   return 1;
            SYM_V:   return 5;
            SYM_X:   return 10;
            SYM_L:   return 50;
            SYM_C:   return 100;
            SYM_D:   return 500;
            default: return 1000;
        endcase
    endfunction

    function automatic void add_to_run(input int v);
        int t;
        t = run_sum + v;
        if (t > SAT_LIMIT) begin
            t = SAT_LIMIT;
            clamp_seen = 1'b1;
        end
        if (t < -SAT_LIMIT) t = -SAT_LIMIT;
        run_sum = t;
    endfunction

    function automatic void push_char(input logic [6:0] c);
        t_out_item e;
        e.out_char  = c;
        e.last_char = 1'b0;
        e.saturated = clamp_seen;
        char_q.push_back(e);
    endfunction

    function automatic void push_place(input int d, input logic [6:0] one, five, ten);
        int k;
        if (d == 9) begin
            push_char(one);
            push_char(ten);
        end else if (d == 4) begin
            push_char(one);
            push_char(five);
        end else begin
            if (d >= 5) begin
                push_char(five);
                d -= 5;
            end
            for (k = 0; k < d; k++) push_char(one);
        end
    endfunction

    // decode one symbol item; at the end of the second numeral queue the run
    function automatic void predict_symbol(input t_in_item it);
        logic [2:0] cur;
        int         total;
        int         gap;
        int         k;
        cur = (it.symbol > SYM_M) ? SYM_M : it.symbol;
        if (held_ok)
            add_to_run((held_sym < cur) ? -sym_weight(held_sym) : sym_weight(held_sym));
        held_sym = cur;
        held_ok  = 1'b1;
        if (!it.end_of_numeral) return;

        add_to_run(sym_weight(cur));
        held_ok  = 1'b0;
        held_sym = SYM_I;
        total    = (run_sum < 0) ? 0 : run_sum;
        run_sum  = 0;
        if (!it.second_numeral) begin
            first_sum = total;
            return;
        end

        gap = first_sum - total;
        if (gap < 0) gap = -gap;
        if (gap > SAT_LIMIT) begin
            gap = SAT_LIMIT;
            clamp_seen = 1'b1;
        end
        if (gap == 0) begin
            push_char(CHR_Z);
            push_char(CHR_E);
            push_char(CHR_R);
            push_char(CHR_O);
        end else begin
            for (k = 0; k < gap / 1000; k++) push_char(CHR_M);
            push_place((gap / 100) % 10, CHR_C, CHR_D, CHR_M);
            push_place((gap / 10) % 10, CHR_X, CHR_L, CHR_C);
            push_place(gap % 10, CHR_I, CHR_V, CHR_X);
        end
        char_q[char_q.size() - 1].last_char = 1'b1;
        first_sum  = 0;
        clamp_seen = 1'b0;
    endfunction

    // prediction on accepted symbols, comparison on accepted characters
    always @(posedge clk) begin
        t_out_item want;
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;

            if (in_valid && !in_stall) predict_symbol(in_item);

            if (out_valid && !out_stall) begin
                if (char_q.size() == 0) begin
                    $error("unexpected character item %h", out_item.out_char);
                    err_cnt++;
                end else begin
                    want = char_q.pop_front();
                    if (out_item.out_char !== want.out_char) begin
                        $error("out_char: expected %h, got %h", want.out_char,
                               out_item.out_char);
                        err_cnt++;
                    end
                    if (out_item.last_char !== want.last_char) begin
                        $error("last_char: expected %b, got %b", want.last_char,
                               out_item.last_char);
                        err_cnt++;
                    end
                    if (out_item.saturated !== want.saturated) begin
                        $error("saturated: expected %b, got %b", want.saturated,
                               out_item.saturated);
                        err_cnt++;
                    end
                end
            end
        end
    end

    // receiver stalls in bursts
    always @(negedge clk) begin
        if (!quiet && stall_left == 0 && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 9);
        out_stall <= (stall_left != 0);
        if (stall_left != 0) stall_left--;
    end

    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("tb: errors");
        $finish;
    end

    // valid stays high on return so a following item goes out back to back
    task automatic send_symbol(input logic [2:0] sym, input logic second, input logic last);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        in_item  <= '{symbol: sym, second_numeral: second, end_of_numeral: last};
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        sent_cnt++;
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (char_q.size() != 0) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic void place_syms(ref logic [2:0] q[$], input int d,
                                       input logic [2:0] one, five, ten);
        int k;
        if (d == 9) begin
            q.push_back(one);
            q.push_back(ten);
        end else if (d == 4) begin
            q.push_back(one);
            q.push_back(five);
        end else begin
            if (d >= 5) begin
                q.push_back(five);
                d -= 5;
            end
            for (k = 0; k < d; k++) q.push_back(one);
        end
    endfunction

    // mixed: random numeral flag before the end item and M sometimes as its alias
    task automatic send_numeral(input int value, input int extra_m, input logic second,
                                input bit mixed);
        logic [2:0] syms[$];
        logic [2:0] sym;
        logic       last;
        int         k;
        for (k = 0; k < value / 1000 + extra_m; k++) syms.push_back(SYM_M);
        place_syms(syms, (value / 100) % 10, SYM_C, SYM_D, SYM_M);
        place_syms(syms, (value / 10) % 10, SYM_X, SYM_L, SYM_C);
        place_syms(syms, value % 10, SYM_I, SYM_V, SYM_X);
        foreach (syms[i]) begin
            last = (i == syms.size() - 1);
            sym  = syms[i];
            if (mixed && sym == SYM_M && $urandom_range(0, 7) == 0) sym = SYM_M_ALIAS;
            send_symbol(sym, (last || !mixed) ? second : 1'($urandom_range(0, 1)), last);
        end
    endtask

    // no first numeral since reset, subtractive pair
    task automatic test_second_alone();
        send_numeral(900, 0, 1'b1, 1'b0);
    endtask

    task automatic test_zero_difference();
        send_numeral(5, 0, 1'b0, 1'b0);
        send_numeral(5, 0, 1'b1, 1'b0);
    endtask

    // four M clamp to 3999; alias code and flag toggles inside the numeral
    task automatic test_clamp();
        send_symbol(SYM_M_ALIAS, 1'b1, 1'b0);
        send_symbol(SYM_M, 1'b0, 1'b0);
        send_symbol(SYM_M, 1'b1, 1'b0);
        send_symbol(SYM_M, 1'b0, 1'b1);
        send_symbol(SYM_I, 1'b1, 1'b1);
    endtask

    // first numeral given twice, then the longest run of characters
    task automatic test_overwrite_longest();
        send_symbol(SYM_X, 1'b0, 1'b1);
        send_symbol(SYM_I, 1'b0, 1'b1);
        send_numeral(3889, 0, 1'b1, 1'b0);
    endtask

    task automatic test_random_traffic();
        int pick;
        int a;
        int b;
        while (sent_cnt < ITEM_TARGET) begin
            if (sent_cnt >= QUIET_FROM) quiet = 1'b1;
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                repeat ($urandom_range(1, 6))
                    send_symbol(3'($urandom), 1'($urandom), 1'($urandom_range(0, 3) == 0));
            end else begin
                a = $urandom_range(0, 1) ? $urandom_range(1, 3999) : $urandom_range(1, 99);
                if ($urandom_range(0, 7) == 0) b = a;
                else b = $urandom_range(0, 1) ? $urandom_range(1, 3999) : $urandom_range(1, 99);
                if ($urandom_range(0, 9) != 0)
                    send_numeral(a, (pick == 1) ? $urandom_range(1, 2) : 0, 1'b0, 1'b1);
                send_numeral(b, 0, 1'b1, 1'b1);
                if ($urandom_range(0, 19) == 0) wait_for_results();
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_second_alone();
        test_zero_difference();
        test_clamp();
        test_overwrite_longest();
        wait_for_results();
        test_random_traffic();

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (err_cnt == 0) $display("tb: clean");
        else $display("tb: errors");
        $finish;
    end

endmodule
